/* rtl/four_level_page_table_walker_unit_defines.svh */
// assertion macros for the four-level page table walker
// used by the top level only, no other dependencies
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PTW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PTW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/ptw_pkg.sv */
// shared types and constants of the page table walker
// no dependencies
package ptw_pkg;

    localparam int VA_W            = 48;
    localparam int PA_W            = 52;
    localparam int WORD_W          = 64;
    localparam int WIDX_W          = 12;
    localparam int IDX_W           = 9;
    localparam int TABLE_ENTRIES   = 512;
    localparam int PAGE_OFS_W      = 12;
    localparam int FIRST_W         = PA_W - 3;
    localparam int STORE_WORDS_DEF = 4096;

    typedef enum logic
    {
        CMD_WRITE     = 1'b0,
        CMD_TRANSLATE = 1'b1
    } ptw_command_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } ptw_state_t;

    // controller to datapath
    typedef struct packed
    {
        logic       write;
        logic       start;
        logic       step;
        logic       finish;
        logic [1:0] level;
    } ptw_cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic out_busy;
    } ptw_status_t;

endpackage

/* rtl/ptw_chan_if.sv */
// handshake channels of the page table walker: request, response, configuration
// depends on ptw_pkg
interface ptw_req_if;
    import ptw_pkg::*;
    logic              valid;
    logic              ready;
    logic              command;
    logic [WIDX_W-1:0] word_index;
    logic [WORD_W-1:0] word_data;
    logic [VA_W-1:0]   virt_addr;

    modport source (output valid, command, word_index, word_data, virt_addr, input ready);
    modport sink   (input valid, command, word_index, word_data, virt_addr, output ready);
endinterface

interface ptw_rsp_if;
    import ptw_pkg::*;
    logic            valid;
    logic            ready;
    logic [PA_W-1:0] phys_addr;
    logic            present;

    modport source (output valid, phys_addr, present, input ready);
    modport sink   (input valid, phys_addr, present, output ready);
endinterface

interface ptw_cfg_if;
    import ptw_pkg::*;
    logic            valid;
    logic            ready;
    logic [PA_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/four_level_page_table_walker_unit.sv */
// Four-level page table walker, top level; depends on ptw_pkg, the channel interfaces,
// ptw_ctrl, ptw_datapath and the defines header. A translate word is accepted from req
// and its result is shown valid on rsp from the output register. The level-four read is
// issued in the accept cycle and each of the four dependent reads of the single-port table
// store returns registered data, the last one being checked in the cycle that loads the
// output register. A write word fills one store word and gives a zero result. One word is
// in flight at a time; req is ready again once the result sits in the output register, so
// a waiting result does not hold up the next request. The store has no reset and no
// clearing pass: a word must be written before any walk reads it. The root table address
// is written over cfg, which is always ready; the user must write it only while no walk is
// in flight, and the block itself does not enforce it.
`include "four_level_page_table_walker_unit_defines.svh"

module four_level_page_table_walker_unit
    import ptw_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    ptw_cfg_if.sink   cfg,
    ptw_req_if.sink   req,
    ptw_rsp_if.source rsp
);

    ptw_cmd_t    cmd;
    ptw_status_t status;
    logic        in_ready;

    assign cfg.ready = 1'b1;
    assign req.ready = in_ready;

    ptw_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_command (req.command),
        .in_ready   (in_ready),
        .status     (status),
        .cmd        (cmd)
    );

    ptw_datapath #(
        .STORE_WORDS (STORE_WORDS)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg.valid),
        .cfg_data   (cfg.data),
        .word_index (req.word_index),
        .word_data  (req.word_data),
        .virt_addr  (req.virt_addr),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .phys_addr  (rsp.phys_addr),
        .present    (rsp.present)
    );

    `PTW_ASSERT_IMPLY(a_unmapped_zero, clk, rst_n, rsp.valid && !rsp.present, rsp.phys_addr == '0, "unmapped result carries a non-zero address")
    `PTW_ASSERT_NEXT(a_walk_follows, clk, rst_n, req.valid && req.ready && (req.command == CMD_TRANSLATE), cmd.step && (cmd.level == 2'd0), "walk did not start after a translate word")
    `PTW_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, cmd.finish, !(rsp.valid && !rsp.ready), "pending result overwritten")

endmodule

/* rtl/ptw_ctrl.sv */
// walk sequencer: accepts a word, steps through the table levels, hands off the result
// depends on ptw_pkg
module ptw_ctrl
    import ptw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_command,
    output logic        in_ready,
    input  ptw_status_t status,
    output ptw_cmd_t    cmd
);

    ptw_state_t state_reg, state_next;
    logic [1:0] level_reg, level_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            level_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        level_next = level_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.level  = level_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_command == CMD_TRANSLATE)
                    begin
                        cmd.start  = 1'b1;
                        level_next = 2'd0;
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        cmd.write  = 1'b1;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                // three intermediate levels follow the root read
                if (level_reg == 2'd2)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    level_next = level_reg + 2'd1;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/ptw_datapath.sv */
// table store, root register, walk registers and the output register
// depends on ptw_pkg
module ptw_datapath
    import ptw_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [PA_W-1:0]   cfg_data,
    input  logic [WIDX_W-1:0] word_index,
    input  logic [WORD_W-1:0] word_data,
    input  logic [VA_W-1:0]   virt_addr,
    input  ptw_cmd_t          cmd,
    output ptw_status_t       status,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [PA_W-1:0]   phys_addr,
    output logic              present
);

    localparam int AW = $clog2(STORE_WORDS);
    localparam logic [FIRST_W-1:0] LAST_FIRST = FIRST_W'(STORE_WORDS - TABLE_ENTRIES);

    logic [WORD_W-1:0] store_mem [STORE_WORDS];

    logic [PA_W-1:0]   root_reg;
    logic [VA_W-1:0]   va_reg;
    logic              fail_reg, fail_next;
    logic [WORD_W-1:0] rdata_reg;
    logic              out_valid_reg;
    logic [PA_W-1:0]   phys_reg;
    logic              present_reg;

    logic [PA_W-1:0]    base;
    logic [IDX_W-1:0]   idx;
    logic [FIRST_W-1:0] first;
    logic               table_ok;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;
    logic               wr_en;
    logic               final_ok;

    // root is taken from the config register, later levels from the last entry read
    always_comb
    begin
        if (cmd.start)
        begin
            base = root_reg;
            idx  = virt_addr[47:39];
        end
        else
        begin
            base = rdata_reg[PA_W-1:0];
            unique case (cmd.level)
                2'd0:    idx = va_reg[38:30];
                2'd1:    idx = va_reg[29:21];
                default: idx = va_reg[20:12];
            endcase
        end
    end

    assign first    = {base[PA_W-1:PAGE_OFS_W], IDX_W'(0)};
    assign table_ok = (first <= LAST_FIRST);
    assign rd_addr  = first[AW-1:0] + AW'(idx);
    assign rd_en    = cmd.start || cmd.step;
    assign wr_en    = cmd.write && (32'(word_index) < 32'(STORE_WORDS));
    assign final_ok = !fail_reg && rdata_reg[0];

    always_comb
    begin
        fail_next = fail_reg;
        if (cmd.write)
        begin
            fail_next = 1'b1;
        end
        else if (cmd.start)
        begin
            fail_next = !table_ok;
        end
        else if (cmd.step)
        begin
            fail_next = fail_reg || !rdata_reg[0] || !table_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[AW'(word_index)] <= word_data;
        end
        if (rd_en)
        begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg      <= '0;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                root_reg <= cfg_data;
            end
            fail_reg <= fail_next;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            va_reg <= virt_addr;
        end
        if (cmd.finish)
        begin
            present_reg <= final_ok;
            phys_reg    <= final_ok ? {rdata_reg[PA_W-1:PAGE_OFS_W], va_reg[PAGE_OFS_W-1:0]}
                                    : '0;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign phys_addr       = phys_reg;
    assign present         = present_reg;

endmodule

/* tb/four_level_page_table_walker_unit_checker.sv */
// result checker for the four-level page table walker: watches cfg, req and rsp,
// keeps its own table store and root address and compares every result word
// depends on ptw_pkg and the channel interfaces ptw_cfg_if, ptw_req_if, ptw_rsp_if
module four_level_page_table_walker_unit_checker
    import ptw_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    ptw_cfg_if   cfg,
    ptw_req_if   req,
    ptw_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding,
    output int   walks_seen,
    output int   walks_mapped,
    output int   writes_seen
);

    localparam logic [WORD_W-1:0] FRAME_MASK = 64'h000F_FFFF_FFFF_F000;

    typedef struct packed
    {
        logic [PA_W-1:0] phys_addr;
        logic            present;
    } walk_result_t;

    logic [WORD_W-1:0] table_words [STORE_WORDS];
    logic [PA_W-1:0]   root_addr;
    walk_result_t      pending_results [$];

    // four dependent reads, root first; a table that does not fit in the store is absent
    function automatic walk_result_t walk_tables(input logic [VA_W-1:0] va);
        walk_result_t      res;
        logic [WORD_W-1:0] entry;
        longint unsigned   first;
        logic [IDX_W-1:0]  idx;
        res   = '0;
        entry = WORD_W'(root_addr);
        for (int lvl = 3; lvl >= 0; lvl--)
        begin
            first = (entry & FRAME_MASK) >> 3;
            if (first + TABLE_ENTRIES > STORE_WORDS)
                return res;
            idx   = va[PAGE_OFS_W + IDX_W*lvl +: IDX_W];
            entry = table_words[first + idx];
            if (!entry[0])
                return res;
        end
        res.phys_addr = {entry[PA_W-1:PAGE_OFS_W], va[PAGE_OFS_W-1:0]};
        res.present   = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch at %0t on %s: got %h, want %h", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        walk_result_t want;
        if (!rst_n)
        begin
            pending_results.delete();
            root_addr    = '0;
            mismatches   = 0;
            outstanding  = 0;
            walks_seen   = 0;
            walks_mapped = 0;
            writes_seen  = 0;
        end
        else
        begin
            // results first, so a word accepted at this edge is never matched against itself
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing expected", 64'(rsp.phys_addr), '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.phys_addr !== want.phys_addr)
                        report_mismatch("phys_addr", 64'(rsp.phys_addr), 64'(want.phys_addr));
                    if (rsp.present !== want.present)
                        report_mismatch("present", 64'(rsp.present), 64'(want.present));
                end
            end
            if (cfg.valid && cfg.ready)
                root_addr = cfg.data;
            if (req.valid && req.ready)
            begin
                if (req.command == CMD_WRITE)
                begin
                    if (req.word_index < STORE_WORDS)
                        table_words[req.word_index] = req.word_data;
                    pending_results.push_back('0);
                    writes_seen++;
                end
                else
                begin
                    want = walk_tables(req.virt_addr);
                    pending_results.push_back(want);
                    walks_seen++;
                    if (want.present)
                        walks_mapped++;
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

/* tb/four_level_page_table_walker_unit_tb.sv */
// testbench top for the four-level page table walker: drives cfg, req and rsp and gives the verdict
// depends on ptw_pkg, the channel interfaces, the walker top level and
// four_level_page_table_walker_unit_checker
module four_level_page_table_walker_unit_tb;
    import ptw_pkg::*;

    localparam int                STORE_WORDS     = STORE_WORDS_DEF;
    localparam int                TABLES          = STORE_WORDS / TABLE_ENTRIES;
    localparam int                RSP_HOLD_CYCLES = 300;
    localparam int                IDLE_LIMIT      = 4000;
    localparam int                DRAIN_CYCLES    = 12;
    localparam int                PHASES          = 8;
    localparam int                PHASE_ITEMS     = 205;
    localparam int                POOL_DEPTH      = 64;
    localparam logic [WORD_W-1:0] FRAME_MASK      = 64'h000F_FFFF_FFFF_F000;

    logic clk = 1'b0;
    logic rst_n;

    ptw_cfg_if cfg ();
    ptw_req_if req ();
    ptw_rsp_if rsp ();

    int mismatches;
    int outstanding;
    int walks_seen;
    int walks_mapped;
    int writes_seen;

    four_level_page_table_walker_unit #(.STORE_WORDS(STORE_WORDS)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    four_level_page_table_walker_unit_checker #(.STORE_WORDS(STORE_WORDS)) walk_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .req          (req),
        .rsp          (rsp),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .walks_seen   (walks_seen),
        .walks_mapped (walks_mapped),
        .writes_seen  (writes_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // what the stimulus side knows of the store, so that no walk reads an unwritten word
    logic [WORD_W-1:0] known_words [STORE_WORDS];
    bit                word_written [STORE_WORDS];
    logic [PA_W-1:0]   cur_root;
    logic [VA_W-1:0]   va_pool [$];
    bit                calm;
    bit                hold_rsp;
    int                items_sent;
    int                root_writes;

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [WIDX_W-1:0] tbl_word(input int tbl, input int ent);
        return WIDX_W'(tbl * TABLE_ENTRIES + ent);
    endfunction

    // first store word on the walk of va that has not been written yet, or -1
    function automatic int first_missing_word(input logic [VA_W-1:0] va, output int level);
        logic [WORD_W-1:0] entry;
        longint unsigned   first;
        longint unsigned   w;
        level = 0;
        entry = WORD_W'(cur_root);
        for (int lvl = 3; lvl >= 0; lvl--)
        begin
            first = (entry & FRAME_MASK) >> 3;
            if (first + TABLE_ENTRIES > STORE_WORDS)
                return -1;
            w = first + va[PAGE_OFS_W + IDX_W*lvl +: IDX_W];
            if (!word_written[w])
            begin
                level = lvl;
                return int'(w);
            end
            entry = known_words[w];
            if (!entry[0])
                return -1;
        end
        return -1;
    endfunction

    // mostly present entries pointing at tables inside the store, the rest broken
    function automatic logic [WORD_W-1:0] random_entry(input bit leaf);
        logic [WORD_W-1:0] e;
        e = {$urandom, $urandom};
        if ($urandom_range(0, 99) < (leaf ? 50 : 85))
            e[PA_W-1:PAGE_OFS_W] = (PA_W-PAGE_OFS_W)'($urandom_range(0, TABLES-1));
        e[0] = ($urandom_range(0, 9) != 0);
        return e;
    endfunction

    // fresh address, or one seen before with a new offset or one new table index
    function automatic logic [VA_W-1:0] pick_va();
        logic [VA_W-1:0] va;
        logic [VA_W-1:0] base;
        int              lvl;
        va = VA_W'({$urandom, $urandom});
        if (va_pool.size() > 0 && $urandom_range(0, 99) < 60)
        begin
            base = va_pool[$urandom_range(0, va_pool.size() - 1)];
            lvl  = $urandom_range(0, 4);
            if (lvl == 4)
                base[PAGE_OFS_W-1:0] = va[PAGE_OFS_W-1:0];
            else
                base[PAGE_OFS_W + IDX_W*lvl +: IDX_W] = va[PAGE_OFS_W + IDX_W*lvl +: IDX_W];
            va = base;
        end
        return va;
    endfunction

    function automatic logic [PA_W-1:0] phase_root(input int p);
        logic [PA_W-1:0] r;
        r = PA_W'({$urandom, $urandom});
        case (p)
            0:       r = '0;
            1:       r = PA_W'((TABLES - 1) * 4096 + 12'hFFF);
            3:       r = '1;
            6:       ;
            default: r = (PA_W'($urandom_range(0, TABLES-1)) << PAGE_OFS_W)
                         | PA_W'(r[PAGE_OFS_W-1:0]);
        endcase
        return r;
    endfunction

    // entered and left at a falling edge; valid stays high when the next word follows at once
    task automatic send_item(input ptw_command_t cmd, input logic [WIDX_W-1:0] idx,
                             input logic [WORD_W-1:0] data, input logic [VA_W-1:0] va);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.command    <= cmd;
        req.word_index <= idx;
        req.word_data  <= data;
        req.virt_addr  <= va;
        if (cmd == CMD_WRITE)
        begin
            known_words[idx]  = data;
            word_written[idx] = 1'b1;
        end
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic write_word(input logic [WIDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        send_item(CMD_WRITE, idx, data, VA_W'({$urandom, $urandom}));
    endtask

    // writes any missing word on the path first, then sends the translate word
    task automatic translate(input logic [VA_W-1:0] va);
        int w;
        int lvl;
        for (int k = 0; k < 4; k++)
        begin
            w = first_missing_word(va, lvl);
            if (w < 0)
                break;
            write_word(WIDX_W'(w), random_entry(lvl == 0));
        end
        send_item(CMD_TRANSLATE, WIDX_W'($urandom), {$urandom, $urandom}, va);
        va_pool.push_back(va);
        if (va_pool.size() > POOL_DEPTH)
            void'(va_pool.pop_front());
    endtask

    // only with the walker idle: every result in, then a drain wait before the root is set
    task automatic set_root(input logic [PA_W-1:0] value);
        req.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
        cur_root = value;
        root_writes++;
    endtask

    initial
    begin : rsp_drive
        int gap;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                rsp.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(negedge clk);
                hold_rsp = 1'b0;
            end
            gap = pick_gap();
            if (gap == 0)
                rsp.ready <= 1'b1;
            else
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(negedge clk);
                rsp.ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
                idle = 0;
            else
                idle++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int target;
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.command    = CMD_WRITE;
        req.word_index = '0;
        req.word_data  = '0;
        req.virt_addr  = '0;
        cfg.valid      = 1'b0;
        cfg.data       = '0;
        calm           = 1'b0;
        hold_rsp       = 1'b0;
        items_sent     = 0;
        root_writes    = 0;
        cur_root       = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // hand-built tables 0..3 chained from entry 0, large-page bit set on the first
        set_root('0);
        write_word(tbl_word(0, 0), 64'h0000_0000_0000_1081);
        write_word(tbl_word(1, 0), 64'h0000_0000_0000_2001);
        write_word(tbl_word(2, 0), 64'h0000_0000_0000_3001);
        write_word(tbl_word(3, 0), 64'hFFFF_FFFF_FFFF_FFFF);
        translate(48'h0000_0000_0000);
        translate(48'h0000_0000_0FFF);
        // missing leaf, missing level two, table past the store end, missing level three
        write_word(tbl_word(3, 1), 64'h0);
        translate(48'h0000_0000_1000);
        write_word(tbl_word(2, 1), 64'h0000_0000_0000_3000);
        translate(48'h0000_0020_0000);
        write_word(tbl_word(1, 1), 64'h0000_0000_0000_8001);
        translate(48'h0000_4000_0000);
        write_word(tbl_word(1, 3), 64'h0);
        translate(48'h0000_C000_0000);
        // top entry with every bit set points far outside the store
        write_word(tbl_word(0, 511), 64'hFFFF_FFFF_FFFF_FFFF);
        translate(48'hFFFF_FFFF_FFFF);
        write_word(tbl_word(0, 2), 64'h0);
        translate(48'h0100_0000_0000);
        // unaligned root, low bits dropped, then a root beyond the store
        set_root(52'h0_0000_0000_1FFF);
        translate(48'h0000_0000_0000);
        set_root('1);
        translate(48'hFFFF_FFFF_FFFF);
        translate(48'h0000_0000_0000);

        for (int p = 0; p < PHASES; p++)
        begin
            set_root(phase_root(p));
            if (p == 2)
            begin
                // receiver holds off while words keep coming, so req must stall
                hold_rsp = 1'b1;
                calm     = 1'b1;
                for (int k = 0; k < 12; k++)
                    translate(pick_va());
            end
            calm   = (p == 5);
            target = items_sent + ((p == 3 || p == 6) ? PHASE_ITEMS / 4 : PHASE_ITEMS);
            while (items_sent < target)
            begin
                if ($urandom_range(0, 99) < 15)
                    write_word(WIDX_W'($urandom), {$urandom, $urandom});
                else
                    translate(pick_va());
            end
            calm = 1'b0;
        end

        req.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d walks (%0d mapped) and %0d store writes over %0d root settings",
                 walks_seen, walks_mapped, writes_seen, root_writes);
        $display("with corner tables, random rebuilt paths, idle gaps and a long response hold");
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/ptw_pkg.sv
rtl/ptw_chan_if.sv
rtl/ptw_ctrl.sv
rtl/ptw_datapath.sv
rtl/four_level_page_table_walker_unit.sv
tb/four_level_page_table_walker_unit_checker.sv
tb/four_level_page_table_walker_unit_tb.sv
